@@ src/sstp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstp_pkg
// Shared constants, register codes, pipeline control type and the
// quarter-wave sine table generator for the stereo sine tone core.
// ----------------------------------------------------------------------------
package sstp_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_WIDTH        = 16;
  localparam int STEP_WIDTH          = 32;
  localparam int GAIN_WIDTH          = 16;
  localparam int COUNT_WIDTH         = 32;
  localparam int ENTRY_WIDTH         = 31;
  localparam int PRODUCT_WIDTH       = ENTRY_WIDTH + GAIN_WIDTH;
  localparam int SCALED_WIDTH        = PRODUCT_WIDTH + 15;
  localparam int ROUND_SHIFT         = 42;
  localparam int ROUNDED_WIDTH       = SCALED_WIDTH - ROUND_SHIFT;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int CFG_DATA_WIDTH      = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_STEP    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RIGHT_STEP   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN         = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOTAL_SAMPLES = 2'd3;

  localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 16'd4096;
  localparam logic [COUNT_WIDTH-1:0] TOTAL_RESET = 32'd48000;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'h8000;

  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam int          TAYLOR_TERMS = 10;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef struct packed {
    logic last;
    logic neg_left;
    logic neg_right;
  } ctrl_t;

  // Entry k of the quarter-wave table, sin(pi/2 * k / 2^addr_bits) in Q1.30
  function automatic logic [ENTRY_WIDTH-1:0] sine_entry(input int k, input int addr_bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) >> addr_bits;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    return ENTRY_WIDTH'(sum);
  endfunction

endpackage

@@ src/sstp_phase.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstp_phase
// Phase accumulators and sample counter. On each input transfer, forms the
// table addresses and signs for the current pair and advances the state.
// ----------------------------------------------------------------------------
module sstp_phase #(
  parameter int PHASE_BITS      = sstp_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = sstp_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               restart,
  input  logic [sstp_pkg::STEP_WIDTH-1:0]    left_step,
  input  logic [sstp_pkg::STEP_WIDTH-1:0]    right_step,
  input  logic [sstp_pkg::COUNT_WIDTH-1:0]   total_samples,
  output logic [TABLE_ADDR_BITS:0]           addr_left,
  output logic [TABLE_ADDR_BITS:0]           addr_right,
  output sstp_pkg::ctrl_t                    ctrl
);

  localparam int ADDR_WIDTH  = TABLE_ADDR_BITS + 1;
  localparam int LOOKUP_BITS = TABLE_ADDR_BITS + 2;
  localparam logic [ADDR_WIDTH-1:0] QUARTER = ADDR_WIDTH'(1) << TABLE_ADDR_BITS;

  logic [PHASE_BITS-1:0]            left_phase;
  logic [PHASE_BITS-1:0]            right_phase;
  logic [PHASE_BITS-1:0]            left_phase_next;
  logic [PHASE_BITS-1:0]            right_phase_next;
  logic [PHASE_BITS-1:0]            left_cur;
  logic [PHASE_BITS-1:0]            right_cur;
  logic [sstp_pkg::COUNT_WIDTH-1:0] sample_index;
  logic [sstp_pkg::COUNT_WIDTH-1:0] sample_index_next;
  logic [sstp_pkg::COUNT_WIDTH-1:0] index_cur;
  logic                             last;

  function automatic logic [ADDR_WIDTH-1:0] table_addr(input logic [PHASE_BITS-1:0] phase);
    logic [LOOKUP_BITS-1:0] lookup;
    logic [ADDR_WIDTH-1:0]  k;
    lookup = phase[PHASE_BITS-1 -: LOOKUP_BITS];
    k      = {1'b0, lookup[TABLE_ADDR_BITS-1:0]};
    return lookup[TABLE_ADDR_BITS] ? (QUARTER - k) : k;
  endfunction

  always_comb begin
    left_cur  = restart ? '0 : left_phase;
    right_cur = restart ? '0 : right_phase;
    index_cur = restart ? '0 : sample_index;
    last      = (index_cur == (total_samples - 32'd1));
    if (last) begin
      left_phase_next   = '0;
      right_phase_next  = '0;
      sample_index_next = '0;
    end else begin
      left_phase_next   = left_cur + PHASE_BITS'(left_step);
      right_phase_next  = right_cur + PHASE_BITS'(right_step);
      sample_index_next = index_cur + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_phase   <= '0;
      right_phase  <= '0;
      sample_index <= '0;
    end else if (accept) begin
      left_phase   <= left_phase_next;
      right_phase  <= right_phase_next;
      sample_index <= sample_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_left      <= table_addr(left_cur);
      addr_right     <= table_addr(right_cur);
      ctrl.last      <= last;
      ctrl.neg_left  <= left_cur[PHASE_BITS-1];
      ctrl.neg_right <= right_cur[PHASE_BITS-1];
    end
  end

endmodule

@@ src/sstp_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstp_sine_rom
// Quarter-wave sine ROM, 2^ADDR_BITS+1 entries in Q1.30, registered read.
// ----------------------------------------------------------------------------
module sstp_sine_rom #(
  parameter int ADDR_BITS = sstp_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [ADDR_BITS:0]                 addr,
  output logic [sstp_pkg::ENTRY_WIDTH-1:0]   data
);

  localparam int DEPTH = (1 << ADDR_BITS) + 1;

  logic [sstp_pkg::ENTRY_WIDTH-1:0] sine_rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    assign sine_rom[g] = sstp_pkg::sine_entry(g, ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= sine_rom[addr];
    end
  end

endmodule

@@ src/sstp_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstp_scale
// Gain multiply (registered), then full-scale scaling, rounding half away
// from zero and saturation to a signed 16-bit sample.
// ----------------------------------------------------------------------------
module sstp_scale (
  input  logic                                    clk,
  input  logic                                    load,
  input  logic [sstp_pkg::ENTRY_WIDTH-1:0]        entry,
  input  logic [sstp_pkg::GAIN_WIDTH-1:0]         gain,
  input  logic                                    negate,
  output logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                    clip
);

  localparam int SW = sstp_pkg::SCALED_WIDTH;
  localparam int RW = sstp_pkg::ROUNDED_WIDTH;

  logic [sstp_pkg::PRODUCT_WIDTH-1:0] product;
  logic [SW-1:0]                      scaled;
  logic [SW-1:0]                      biased;
  logic [RW-1:0]                      rounded;
  logic [RW-1:0]                      negated;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= entry * gain;
    end
  end

  // times 32767 as a shift and subtract
  always_comb begin
    scaled  = {product, 15'b0} - SW'(product);
    biased  = scaled + (SW'(1) << (sstp_pkg::ROUND_SHIFT - 1));
    rounded = RW'(biased >> sstp_pkg::ROUND_SHIFT);
    negated = RW'(0) - rounded;
    clip    = 1'b0;
    if (negate) begin
      if (rounded > RW'(32768)) begin
        sample = sstp_pkg::SAMPLE_MIN;
        clip   = 1'b1;
      end else begin
        sample = negated[sstp_pkg::SAMPLE_WIDTH-1:0];
      end
    end else begin
      if (rounded > RW'(32767)) begin
        sample = sstp_pkg::SAMPLE_MAX;
        clip   = 1'b1;
      end else begin
        sample = rounded[sstp_pkg::SAMPLE_WIDTH-1:0];
      end
    end
  end

endmodule

@@ src/stereo_sine_tone_pcm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_sine_tone_pcm_core
// Stereo direct digital synthesis sine tone source, 16-bit PCM pairs.
// ----------------------------------------------------------------------------
// One left/right sample pair per input transfer, one transfer per cycle
// sustained while the output is not stalled. A pair passes through four
// registers: phase/address, sine ROM read, gain product and output
// register. Each channel has its own quarter-wave ROM of
// 2^TABLE_ADDR_BITS+1 entries. Configuration writes take effect at once and
// are to be made while no pair is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module stereo_sine_tone_pcm_core #(
  parameter int PHASE_BITS      = sstp_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = sstp_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sstp_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [sstp_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     restart,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] left_sample,
  output logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] right_sample,
  output logic                                     last_sample,
  output logic                                     clipped
);

  logic [sstp_pkg::STEP_WIDTH-1:0]  left_step;
  logic [sstp_pkg::STEP_WIDTH-1:0]  right_step;
  logic [sstp_pkg::GAIN_WIDTH-1:0]  gain;
  logic [sstp_pkg::COUNT_WIDTH-1:0] total_samples;

  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;
  logic accept;

  logic [TABLE_ADDR_BITS:0]          addr_left;
  logic [TABLE_ADDR_BITS:0]          addr_right;
  logic [sstp_pkg::ENTRY_WIDTH-1:0]  entry_left;
  logic [sstp_pkg::ENTRY_WIDTH-1:0]  entry_right;
  sstp_pkg::ctrl_t                   ctrl1;
  sstp_pkg::ctrl_t                   ctrl2;
  sstp_pkg::ctrl_t                   ctrl3;

  logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] left_next;
  logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] right_next;
  logic                                     clip_left;
  logic                                     clip_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_step     <= '0;
      right_step    <= '0;
      gain          <= sstp_pkg::GAIN_RESET;
      total_samples <= sstp_pkg::TOTAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sstp_pkg::CFG_LEFT_STEP:     left_step     <= cfg_data;
        sstp_pkg::CFG_RIGHT_STEP:    right_step    <= cfg_data;
        sstp_pkg::CFG_GAIN:          gain          <= cfg_data[sstp_pkg::GAIN_WIDTH-1:0];
        sstp_pkg::CFG_TOTAL_SAMPLES: total_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when the one after it is empty or moving
  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  sstp_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .restart       (restart),
    .left_step     (left_step),
    .right_step    (right_step),
    .total_samples (total_samples),
    .addr_left     (addr_left),
    .addr_right    (addr_right),
    .ctrl          (ctrl1)
  );

  sstp_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom_left (
    .clk  (clk),
    .load (s2_ready),
    .addr (addr_left),
    .data (entry_left)
  );

  sstp_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom_right (
    .clk  (clk),
    .load (s2_ready),
    .addr (addr_right),
    .data (entry_right)
  );

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      ctrl2 <= ctrl1;
    end
    if (s3_ready) begin
      ctrl3 <= ctrl2;
    end
  end

  sstp_scale u_scale_left (
    .clk    (clk),
    .load   (s3_ready),
    .entry  (entry_left),
    .gain   (gain),
    .negate (ctrl3.neg_left),
    .sample (left_next),
    .clip   (clip_left)
  );

  sstp_scale u_scale_right (
    .clk    (clk),
    .load   (s3_ready),
    .entry  (entry_right),
    .gain   (gain),
    .negate (ctrl3.neg_right),
    .sample (right_next),
    .clip   (clip_right)
  );

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      left_sample  <= left_next;
      right_sample <= right_next;
      last_sample  <= ctrl3.last;
      clipped      <= clip_left || clip_right;
    end
  end

endmodule

@@ src/sstp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstp_checker
// Port-level checks on the stereo sine tone core, bound to the top level.
// ----------------------------------------------------------------------------
module sstp_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_ready,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] left_sample,
  input logic signed [sstp_pkg::SAMPLE_WIDTH-1:0] right_sample,
  input logic                                     last_sample,
  input logic                                     clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_sample) &&
      $stable(right_sample) && $stable(last_sample) && $stable(clipped))
    else $error("result changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (left_sample == sstp_pkg::SAMPLE_MAX) || (left_sample == sstp_pkg::SAMPLE_MIN) ||
      (right_sample == sstp_pkg::SAMPLE_MAX) || (right_sample == sstp_pkg::SAMPLE_MIN))
    else $error("clip flagged without a saturated sample");

endmodule

bind stereo_sine_tone_pcm_core sstp_checker u_sstp_checker (.*);

@@ dv/tb_stereo_sine_tone_pcm_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_sine_tone_pcm_core
// Self-checking bench for the stereo sine tone core. A tone predictor keeps
// its own phases, sample count and quarter-wave table, and forecasts every
// PCM pair from the restart flag of each input transfer. Each output pair
// is compared field by field with the oldest forecast. Directed tests cover
// reset values, quadrant peaks, gain extremes with clipping, run length,
// restart on the last pair, zero and lowered totals. Random tone runs follow,
// with bursty sender gaps and receiver stalls, then a gap-free stream.
// ----------------------------------------------------------------------------
module tb_stereo_sine_tone_pcm_core;
  import sstp_pkg::*;

  localparam int          CYCLE_LIMIT     = 500000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          QUARTER         = 1024;
  localparam logic [63:0] QUARTER_PI_STEP = 64'd1686629713;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           last;
    logic                           clip;
  } tone_pair_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]     cfg_index = CFG_LEFT_STEP;
  logic [CFG_DATA_WIDTH-1:0]      cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           restart = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;
  logic                           last_sample;
  logic                           clipped;

  logic [30:0]            sine_quarter [0:QUARTER];
  logic [STEP_WIDTH-1:0]  tone_left_step  = '0;
  logic [STEP_WIDTH-1:0]  tone_right_step = '0;
  logic [GAIN_WIDTH-1:0]  tone_gain       = GAIN_RESET;
  logic [COUNT_WIDTH-1:0] tone_total      = TOTAL_RESET;
  logic [31:0]            tone_left_phase  = '0;
  logic [31:0]            tone_right_phase = '0;
  logic [COUNT_WIDTH-1:0] tone_index       = '0;

  tone_pair_t expected_pairs[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  bit         gaps_on     = 1'b1;
  bit         stalls_on   = 1'b1;

  stereo_sine_tone_pcm_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_sample  (last_sample),
    .clipped      (clipped)
  );

  always #6 clk = ~clk;

  function automatic void fill_sine_quarter();
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (64'(k) * QUARTER_PI_STEP) >> 10;
      term = x;
      acc  = signed'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / (64'(2 * n) * 64'(2 * n + 1));
        acc  = (n % 2 == 1) ? acc - signed'(term) : acc + signed'(term);
      end
      if (acc < 0) begin
        acc = '0;
      end
      if (acc > 64'sd1073741824) begin
        acc = 64'sd1073741824;
      end
      sine_quarter[k] = acc[30:0];
    end
  endfunction

  // Returns {clip, sample} for one channel at the given phase
  function automatic logic [SAMPLE_WIDTH:0] tone_sample(input logic [31:0] phase,
                                                        input logic [GAIN_WIDTH-1:0] g);
    logic [11:0] addr;
    logic [30:0] entry;
    logic [63:0] mag;
    logic [63:0] rounded;
    logic        clip;
    addr    = phase[31:20];
    entry   = addr[10] ? sine_quarter[QUARTER - int'(addr[9:0])] : sine_quarter[addr[9:0]];
    mag     = 64'(entry) * 64'd32767 * 64'(g);
    rounded = (mag + (64'd1 << 41)) >> 42;
    clip    = 1'b0;
    if (addr[11]) begin
      if (rounded > 64'd32768) begin
        rounded = 64'd32768;
        clip    = 1'b1;
      end
      rounded = -rounded;
    end else if (rounded > 64'd32767) begin
      rounded = 64'd32767;
      clip    = 1'b1;
    end
    return {clip, rounded[SAMPLE_WIDTH-1:0]};
  endfunction

  task automatic predict_pair(input logic rs);
    tone_pair_t            pair;
    logic [SAMPLE_WIDTH:0] l;
    logic [SAMPLE_WIDTH:0] r;
    if (rs) begin
      tone_left_phase  = '0;
      tone_right_phase = '0;
      tone_index       = '0;
    end
    l          = tone_sample(tone_left_phase, tone_gain);
    r          = tone_sample(tone_right_phase, tone_gain);
    pair.left  = l[SAMPLE_WIDTH-1:0];
    pair.right = r[SAMPLE_WIDTH-1:0];
    pair.clip  = l[SAMPLE_WIDTH] | r[SAMPLE_WIDTH];
    pair.last  = (tone_index == tone_total - 32'd1);
    if (pair.last) begin
      tone_left_phase  = '0;
      tone_right_phase = '0;
      tone_index       = '0;
    end else begin
      tone_left_phase  = tone_left_phase + tone_left_step;
      tone_right_phase = tone_right_phase + tone_right_step;
      tone_index       = tone_index + 32'd1;
    end
    expected_pairs.push_back(pair);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic send_pair(input logic rs);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pair(rs);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEFT_STEP:     tone_left_step  = data;
      CFG_RIGHT_STEP:    tone_right_step = data;
      CFG_GAIN:          tone_gain       = data[GAIN_WIDTH-1:0];
      CFG_TOTAL_SAMPLES: tone_total      = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every forecast pair has left the core
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'($urandom_range(1, 4095));
      3:       return 32'($urandom_range(1, 64)) << 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain_word();
    logic [15:0] g;
    case ($urandom_range(0, 5))
      0:       g = 16'd0;
      1:       g = 16'hffff;
      2:       g = GAIN_RESET;
      3:       g = 16'($urandom_range(0, 4096));
      default: g = 16'($urandom_range(4097, 65535));
    endcase
    return {16'($urandom), g};
  endfunction

  function automatic logic [31:0] pick_total();
    case ($urandom_range(0, 9))
      0:       return 32'd1;
      6:       return 32'($urandom_range(65, 600));
      7:       return $urandom;
      8:       return 32'd0;
      default: return 32'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic load_random_tone();
    write_reg(CFG_LEFT_STEP, pick_step());
    write_reg(CFG_RIGHT_STEP, pick_step());
    write_reg(CFG_GAIN, pick_gain_word());
    if ($urandom_range(0, 4) != 0) begin
      write_reg(CFG_TOTAL_SAMPLES, pick_total());
    end
  endtask

  task automatic test_reset_state();
    settle();
    repeat (3) send_pair(1'b0);
  endtask

  task automatic test_tone_extremes();
    settle();
    write_reg(CFG_LEFT_STEP, 32'h4000_0000);
    write_reg(CFG_RIGHT_STEP, 32'hffff_ffff);
    write_reg(CFG_GAIN, 32'ha5a5_ffff);
    send_pair(1'b1);
    repeat (3) send_pair(1'b0);
    settle();
    write_reg(CFG_GAIN, 32'h0);
    repeat (2) send_pair(1'b0);
    settle();
    write_reg(CFG_GAIN, {16'hffff, GAIN_RESET});
    send_pair(1'b1);
    repeat (3) send_pair(1'b0);
  endtask

  task automatic test_run_length();
    settle();
    write_reg(CFG_TOTAL_SAMPLES, 32'd1);
    send_pair(1'b0);
    send_pair(1'b1);
    settle();
    write_reg(CFG_TOTAL_SAMPLES, 32'd3);
    send_pair(1'b0);
    send_pair(1'b0);
    send_pair(1'b1);
    settle();
    write_reg(CFG_TOTAL_SAMPLES, 32'd0);
    repeat (2) send_pair(1'b0);
    settle();
    write_reg(CFG_TOTAL_SAMPLES, 32'd2);
    repeat (2) send_pair(1'b0);
  endtask

  task automatic test_random_tones();
    int n;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      load_random_tone();
      n = $urandom_range(80, 130);
      for (int i = 0; i < n; i++) begin
        send_pair($urandom_range(0, 31) == 0);
        if (ph == 4 && i == n / 2) begin
          settle();
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    settle();
    write_reg(CFG_LEFT_STEP, $urandom);
    write_reg(CFG_RIGHT_STEP, 32'($urandom_range(1, 64)) << 20);
    write_reg(CFG_GAIN, 32'($urandom_range(4097, 65535)));
    write_reg(CFG_TOTAL_SAMPLES, 32'($urandom_range(2, 40)));
    repeat (150) send_pair($urandom_range(0, 31) == 0);
  endtask

  initial begin
    fill_sine_quarter();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_tone_extremes();
    test_run_length();
    test_random_tones();
    test_steady_stream();
    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    @(negedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    tone_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("output transfer with no pair forecast");
      end else begin
        want = expected_pairs.pop_front();
        if (left_sample !== want.left) begin
          report_mismatch($sformatf("left_sample %0d, want %0d", left_sample, want.left));
        end
        if (right_sample !== want.right) begin
          report_mismatch($sformatf("right_sample %0d, want %0d", right_sample, want.right));
        end
        if (last_sample !== want.last) begin
          report_mismatch($sformatf("last_sample %b, want %b", last_sample, want.last));
        end
        if (clipped !== want.clip) begin
          report_mismatch($sformatf("clipped %b, want %b", clipped, want.clip));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

@@ sim.f @@
src/sstp_pkg.sv
src/sstp_phase.sv
src/sstp_sine_rom.sv
src/sstp_scale.sv
src/stereo_sine_tone_pcm_core.sv
src/sstp_checker.sv
dv/tb_stereo_sine_tone_pcm_core.sv
